>>> rtl/pdlz_pkg.sv
// ----------------------------------------------------------------------------
// pdlz_pkg
// Shared types and constants for the PalmDoc LZ77 decompressor.
// ----------------------------------------------------------------------------
package pdlz_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 2048;
	localparam int unsigned DIST_W            = 11;
	localparam int unsigned LEN_W             = 4;
	localparam int unsigned PEND_W            = 6;
	localparam int unsigned WORD_W            = 14;

	localparam logic [7:0]       LIT_RUN_MAX = 8'h08;
	localparam logic [7:0]       PAIR_BASE   = 8'h80;
	localparam logic [7:0]       SPACE_BASE  = 8'hC0;
	localparam logic [7:0]       SPACE_CHAR  = 8'h20;
	localparam logic [7:0]       SPACE_XOR   = 8'h80;
	localparam logic [LEN_W-1:0] LEN_BIAS    = 4'd3;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       record_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       bad_distance;
	} out_item_t;

	typedef enum logic [2:0] {
		MODE_CODE = 3'b001,
		MODE_LIT  = 3'b010,
		MODE_PAIR = 3'b100
	} mode_t;

	typedef enum logic [2:0] {
		JOB_IMM   = 3'b001,
		JOB_SPACE = 3'b010,
		JOB_COPY  = 3'b100
	} job_kind_t;

endpackage

>>> rtl/pdlz_hist_mem.sv
// ----------------------------------------------------------------------------
// pdlz_hist_mem
// History ring storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pdlz_hist_mem import pdlz_pkg::*; #(
	parameter int unsigned DEPTH = HISTORY_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pdlz_out_fifo.sv
// ----------------------------------------------------------------------------
// pdlz_out_fifo
// Two-entry result buffer; its ready comes from a register only.
// ----------------------------------------------------------------------------
module pdlz_out_fifo import pdlz_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  out_item_t push_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	out_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign res_valid  = (cnt_q != 2'd0);
	assign res_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/pdlz_ctrl.sv
// ----------------------------------------------------------------------------
// pdlz_ctrl
// Code byte decoder, byte sequencer and history read/emit stage.
// ----------------------------------------------------------------------------
module pdlz_ctrl import pdlz_pkg::*; #(
	parameter int unsigned DEPTH = HISTORY_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  in_item_t      item,
	output logic          push_valid,
	input  logic          push_ready,
	output out_item_t     push_item,
	output logic          hist_we,
	output logic [AW-1:0] hist_waddr,
	output logic [7:0]    hist_wdata,
	output logic          hist_re,
	output logic [AW-1:0] hist_raddr,
	input  logic [7:0]    hist_rdata
);

	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	// Decoder state.
	mode_t             mode_q;
	logic [LEN_W-1:0]  lit_left_q;
	logic [PEND_W-1:0] pend_hi_q;
	logic [AW-1:0]     wi_q;
	logic [CW-1:0]     count_q;

	// Job being sequenced.
	job_kind_t         job_kind_q;
	logic [LEN_W-1:0]  job_left_q;
	logic [7:0]        job_byte_q;
	logic [DIST_W-1:0] job_dist_q;
	logic              job_first_q;
	logic              job_bad_q;
	logic [AW-1:0]     src_q;

	// Emit stage.
	logic          s1_valid_q;
	logic          s1_mem_s1;
	logic [7:0]    s1_imm_s1;
	logic          s1_bad_s1;
	logic          s1_last_s1;
	logic [AW-1:0] s1_waddr_s1;
	logic          s1_fwd_s1;
	logic [7:0]    s1_fwd_data_s1;

	logic              s1_fire;
	logic              s1_free;
	logic              issue;
	logic              accept;
	logic [7:0]        s1_byte;

	mode_t             mode_eff;
	mode_t             mode_d;
	logic [LEN_W-1:0]  lit_eff;
	logic [LEN_W-1:0]  lit_next;
	logic [LEN_W-1:0]  lit_d;
	logic [PEND_W-1:0] pend_eff;
	logic [PEND_W-1:0] pend_d;
	logic [WORD_W-1:0] word;
	job_kind_t         ld_kind;
	logic [LEN_W-1:0]  ld_left;
	logic [7:0]        ld_byte;
	logic [DIST_W-1:0] ld_dist;

	logic [CW-1:0]     dist_ext;
	logic [CW-1:0]     wi_ext;
	logic [CW-1:0]     src_wide;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     src_next;
	logic              bad_now;
	logic              is_copy;
	logic [7:0]        req_byte;

	assign s1_fire    = s1_valid_q && push_ready;
	assign s1_free    = !s1_valid_q || s1_fire;
	assign issue      = (job_left_q != '0) && s1_free;
	assign item_ready = (job_left_q == '0) || ((job_left_q == LEN_W'(1)) && issue);
	assign accept     = item_valid && item_ready;

	// Decode of the incoming byte; a record start restarts in code mode.
	always_comb begin
		mode_eff = item.record_start ? MODE_CODE : mode_q;
		lit_eff  = item.record_start ? '0 : lit_left_q;
		pend_eff = item.record_start ? '0 : pend_hi_q;
		word     = {pend_eff, item.code_byte};
		lit_next = (lit_eff == '0) ? '0 : lit_eff - LEN_W'(1);
		mode_d   = MODE_CODE;
		lit_d    = lit_eff;
		pend_d   = pend_eff;
		ld_kind  = JOB_IMM;
		ld_left  = '0;
		ld_byte  = item.code_byte;
		ld_dist  = '0;
		unique case (mode_eff)
			MODE_LIT: begin
				ld_left = LEN_W'(1);
				lit_d   = lit_next;
				mode_d  = (lit_next == '0) ? MODE_CODE : MODE_LIT;
			end
			MODE_PAIR: begin
				ld_kind = JOB_COPY;
				ld_left = LEN_W'(word[2:0]) + LEN_BIAS;
				ld_dist = word[WORD_W-1:3];
				pend_d  = '0;
			end
			default: begin
				priority if ((item.code_byte != 8'h00) && (item.code_byte <= LIT_RUN_MAX)) begin
					lit_d  = item.code_byte[LEN_W-1:0];
					mode_d = MODE_LIT;
				end else if (item.code_byte < PAIR_BASE) begin
					ld_left = LEN_W'(1);
				end else if (item.code_byte >= SPACE_BASE) begin
					ld_kind = JOB_SPACE;
					ld_left = LEN_W'(2);
					ld_byte = item.code_byte ^ SPACE_XOR;
				end else begin
					pend_d = item.code_byte[PEND_W-1:0];
					mode_d = MODE_PAIR;
				end
			end
		endcase
	end

	// Source address and distance check for the byte being issued.
	always_comb begin
		dist_ext = CW'(job_dist_q);
		wi_ext   = CW'(wi_q);
		if (wi_ext >= dist_ext) begin
			src_wide = wi_ext - dist_ext;
		end else begin
			src_wide = wi_ext + DEPTH_C - dist_ext;
		end
		rd_addr  = job_first_q ? src_wide[AW-1:0] : src_q;
		src_next = (rd_addr == LAST_ADDR) ? '0 : rd_addr + AW'(1);
		bad_now  = job_first_q ? ((job_dist_q == '0) || (dist_ext > count_q)) : job_bad_q;
		is_copy  = (job_kind_q == JOB_COPY);
		req_byte = job_byte_q;
		unique case (job_kind_q)
			JOB_IMM:   req_byte = job_byte_q;
			JOB_SPACE: req_byte = (job_left_q == LEN_W'(2)) ? SPACE_CHAR : job_byte_q;
			JOB_COPY:  req_byte = 8'h00;
			default:   req_byte = job_byte_q;
		endcase
	end

	always_comb begin
		if (s1_bad_s1) begin
			s1_byte = 8'h00;
		end else if (s1_mem_s1) begin
			s1_byte = s1_fwd_s1 ? s1_fwd_data_s1 : hist_rdata;
		end else begin
			s1_byte = s1_imm_s1;
		end
	end

	assign hist_re    = issue && is_copy;
	assign hist_raddr = rd_addr;
	assign hist_we    = s1_fire;
	assign hist_waddr = s1_waddr_s1;
	assign hist_wdata = s1_byte;

	assign push_valid             = s1_valid_q;
	assign push_item.out_byte     = s1_byte;
	assign push_item.last_of_run  = s1_last_s1;
	assign push_item.bad_distance = s1_bad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CODE;
			lit_left_q  <= '0;
			pend_hi_q   <= '0;
			wi_q        <= '0;
			count_q     <= '0;
			job_left_q  <= '0;
			job_first_q <= 1'b0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_d;
				lit_left_q  <= lit_d;
				pend_hi_q   <= pend_d;
				job_left_q  <= ld_left;
				job_first_q <= 1'b1;
			end else if (issue) begin
				job_left_q  <= job_left_q - LEN_W'(1);
				job_first_q <= 1'b0;
			end
			if (accept && item.record_start) begin
				wi_q    <= '0;
				count_q <= '0;
			end else if (issue) begin
				wi_q <= (wi_q == LAST_ADDR) ? '0 : wi_q + AW'(1);
				if (count_q != DEPTH_C) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_kind_q <= ld_kind;
			job_byte_q <= ld_byte;
			job_dist_q <= ld_dist;
		end else if (issue) begin
			src_q     <= src_next;
			job_bad_q <= bad_now;
		end
		if (issue) begin
			s1_mem_s1      <= is_copy;
			s1_imm_s1      <= req_byte;
			s1_bad_s1      <= is_copy && bad_now;
			s1_last_s1     <= (job_left_q == LEN_W'(1));
			s1_waddr_s1    <= wi_q;
			// A read of the entry being written this cycle takes the new byte.
			s1_fwd_s1      <= is_copy && s1_fire && (s1_waddr_s1 == rd_addr);
			s1_fwd_data_s1 <= s1_byte;
		end
	end

	a_lit_mode_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_LIT) |-> (lit_left_q != '0))
		else $error("literal mode with an empty run");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("decoded count beyond history depth");

	a_index_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < DEPTH_C) |-> (CW'(wi_q) == count_q))
		else $error("write index out of step with decoded count");

	a_fwd_only_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_fwd_s1) |-> s1_mem_s1)
		else $error("forwarded byte on a non-copy transfer");

endmodule

>>> rtl/palmdoc_lz77_decompressor.sv
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor
// PalmDoc LZ77 decoder with a history ring in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload     Handshake
// code      in         in_item_t   code_valid / code_ready
// dec       out        out_item_t  dec_valid / dec_ready
//
// One output byte is issued per cycle while the output buffer has room: one
// for a literal or plain byte, two for a space pair, 3 to 10 for a back
// reference via the single history read port. Each passes the emit register.
// Reset clears the decoder state; the history memory is not cleared.
// A two-entry output buffer with registered ready decouples output stalls.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor import pdlz_pkg::*; #(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      code_valid,
	output logic      code_ready,
	input  in_item_t  code_item,
	output logic      dec_valid,
	input  logic      dec_ready,
	output out_item_t dec_item
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);

	logic          push_valid;
	logic          push_ready;
	out_item_t     push_item;
	logic          hist_we;
	logic [AW-1:0] hist_waddr;
	logic [7:0]    hist_wdata;
	logic          hist_re;
	logic [AW-1:0] hist_raddr;
	logic [7:0]    hist_rdata;

	pdlz_ctrl #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (code_valid),
		.item_ready (code_ready),
		.item       (code_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.hist_we    (hist_we),
		.hist_waddr (hist_waddr),
		.hist_wdata (hist_wdata),
		.hist_re    (hist_re),
		.hist_raddr (hist_raddr),
		.hist_rdata (hist_rdata)
	);

	pdlz_hist_mem #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	pdlz_out_fifo u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.res_valid  (dec_valid),
		.res_ready  (dec_ready),
		.res_item   (dec_item)
	);

endmodule

>>> sim/palmdoc_lz77_decompressor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_tb
// Self-checking testbench for the PalmDoc LZ77 decompressor. A directed
// sequence covers every code class, run lengths, space pairs, overlapping,
// zero and out-of-range copies, and records cut short. Random records follow,
// ending in one long record that fills the whole history window. An
// in-bench decoder predicts every output byte and its flags, and both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_tb;
	import pdlz_pkg::*;

	localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
	localparam int MAX_DIST   = 2047;
	localparam int HOLD_AT    = 1500;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_CYC  = 20;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      code_valid = 1'b0;
	logic      code_ready;
	in_item_t  code_item  = '0;
	logic      dec_valid;
	logic      dec_ready  = 1'b0;
	out_item_t dec_item;

	palmdoc_lz77_decompressor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_item  (code_item),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec_item   (dec_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Decoder state mirrored by the predictor.
	logic [7:0]  hist_mem [HIST_DEPTH];
	logic [10:0] hist_wr   = '0;
	logic [11:0] out_count = '0;
	mode_t       dec_mode  = MODE_CODE;
	logic [3:0]  lits_left = '0;
	logic [5:0]  held_high = '0;

	in_item_t  pending_codes[$];
	out_item_t step_bytes[$];
	out_item_t expected_bytes[$];
	out_item_t want_byte;
	int        mismatches = 0;

	int gen_count = 0;
	bit gen_first = 1'b0;

	int burst_left = 1;
	int gap_left   = 0;
	int rx_cycle   = 0;
	int stall_left = 0;

	function automatic int min_of(int a, int b);
		return (a < b) ? a : b;
	endfunction

	function automatic void push_byte(logic [7:0] b, logic bad);
		out_item_t r;
		hist_mem[hist_wr] = b;
		hist_wr = hist_wr + 11'd1;
		if (out_count < HIST_DEPTH)
			out_count = out_count + 12'd1;
		r.out_byte     = b;
		r.last_of_run  = 1'b0;
		r.bad_distance = bad;
		step_bytes.push_back(r);
	endfunction

	function automatic void decode_code_byte(in_item_t it);
		logic [7:0]  c;
		logic [13:0] word;
		logic [10:0] back_dist;
		logic [10:0] src;
		int          len;
		logic        bad;
		out_item_t   r;
		c = it.code_byte;
		if (it.record_start) begin
			hist_wr   = '0;
			out_count = '0;
			dec_mode  = MODE_CODE;
			lits_left = '0;
			held_high = '0;
		end
		case (dec_mode)
			MODE_LIT: begin
				push_byte(c, 1'b0);
				if (lits_left != 0)
					lits_left = lits_left - 4'd1;
				if (lits_left == 0)
					dec_mode = MODE_CODE;
			end
			MODE_PAIR: begin
				word      = {held_high, c};
				back_dist = word[13:3];
				len       = int'(word[2:0]) + int'(LEN_BIAS);
				bad       = (back_dist == 0) || (12'(back_dist) > out_count);
				dec_mode  = MODE_CODE;
				held_high = '0;
				for (int k = 0; k < len; k++) begin
					src = hist_wr - back_dist;
					push_byte(bad ? 8'h00 : hist_mem[src], bad);
				end
			end
			default: begin
				dec_mode = MODE_CODE;
				if (c >= 8'h01 && c <= LIT_RUN_MAX) begin
					lits_left = c[3:0];
					dec_mode  = MODE_LIT;
				end else if (c < PAIR_BASE) begin
					push_byte(c, 1'b0);
				end else if (c >= SPACE_BASE) begin
					push_byte(SPACE_CHAR, 1'b0);
					push_byte(c ^ SPACE_XOR, 1'b0);
				end else begin
					held_high = c[5:0];
					dec_mode  = MODE_PAIR;
				end
			end
		endcase
		for (int i = 0; i < step_bytes.size(); i++) begin
			r = step_bytes[i];
			r.last_of_run = (i == step_bytes.size() - 1);
			expected_bytes.push_back(r);
		end
		step_bytes.delete();
	endfunction

	function automatic void add_code(logic [7:0] c);
		in_item_t it;
		it.code_byte    = c;
		it.record_start = gen_first;
		gen_first = 1'b0;
		pending_codes.push_back(it);
	endfunction

	function automatic void start_record();
		gen_first = 1'b1;
		gen_count = 0;
	endfunction

	function automatic void bump(int n);
		gen_count = min_of(gen_count + n, HIST_DEPTH);
	endfunction

	function automatic void tok_plain(logic [7:0] c);
		add_code(c);
		bump(1);
	endfunction

	function automatic void tok_space(logic [7:0] c);
		add_code(c);
		bump(2);
	endfunction

	function automatic void tok_run(int n);
		add_code(8'(n));
		repeat (n) add_code(8'($urandom_range(0, 255)));
		bump(n);
	endfunction

	function automatic void tok_ref(int back_dist, int len);
		logic [10:0] d;
		logic [2:0]  l;
		d = 11'(back_dist);
		l = 3'(len - int'(LEN_BIAS));
		add_code(PAIR_BASE | {2'b00, d[10:5]});
		add_code({d[4:0], l});
		bump(len);
	endfunction

	function automatic void tok_random();
		int k;
		int lim;
		k = $urandom_range(0, 15);
		if (k >= 8 && k <= 14 && gen_count == 0)
			k = 1;
		if (k <= 3) begin
			tok_plain((k == 0) ? 8'h00 : 8'($urandom_range(9, 127)));
		end else if (k <= 5) begin
			tok_space(8'($urandom_range(192, 255)));
		end else if (k <= 7) begin
			tok_run($urandom_range(1, 8));
		end else if (k <= 14) begin
			lim = min_of(gen_count, MAX_DIST);
			if (k == 8)
				tok_ref($urandom_range(1, min_of(lim, 3)), $urandom_range(3, 10));
			else
				tok_ref($urandom_range(1, lim), $urandom_range(3, 10));
		end else begin
			if (gen_count >= MAX_DIST || $urandom_range(0, 1) == 0)
				tok_ref(0, $urandom_range(3, 10));
			else
				tok_ref($urandom_range(gen_count + 1, MAX_DIST), $urandom_range(3, 10));
		end
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s", $time, msg);
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid <= 1'b0;
			gap_left   <= 0;
			burst_left <= 1;
		end else begin
			if (code_valid && code_ready)
				decode_code_byte(code_item);
			if (!code_valid || code_ready) begin
				if (gap_left != 0) begin
					code_valid <= 1'b0;
					gap_left   <= gap_left - 1;
				end else if (pending_codes.size() != 0) begin
					code_item  <= pending_codes.pop_front();
					code_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					code_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: free-running, periodic and random stall phases, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_ready  <= 1'b0;
			rx_cycle   <= 0;
			stall_left <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
				dec_ready <= 1'b0;
			end else if (stall_left != 0) begin
				dec_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				case (rx_cycle[8:7])
					2'd0: dec_ready <= 1'b1;
					2'd1: dec_ready <= (rx_cycle[1:0] != 2'b11);
					default: begin
						if ($urandom_range(0, 3) == 0) begin
							dec_ready  <= 1'b0;
							stall_left <= $urandom_range(0, 5);
						end else begin
							dec_ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dec_valid && dec_ready) begin
			if (expected_bytes.size() == 0) begin
				note_mismatch($sformatf("unexpected output byte %02h last %0b bad %0b",
					dec_item.out_byte, dec_item.last_of_run, dec_item.bad_distance));
			end else begin
				want_byte = expected_bytes.pop_front();
				if (dec_item.out_byte !== want_byte.out_byte
						|| dec_item.last_of_run !== want_byte.last_of_run
						|| dec_item.bad_distance !== want_byte.bad_distance)
					note_mismatch($sformatf(
						"expected byte %02h last %0b bad %0b, got byte %02h last %0b bad %0b",
						want_byte.out_byte, want_byte.last_of_run, want_byte.bad_distance,
						dec_item.out_byte, dec_item.last_of_run, dec_item.bad_distance));
			end
		end
	end

	initial begin
		// Directed sequence.
		start_record();
		tok_plain(8'h00);
		tok_plain(8'h09);
		tok_plain(8'h7F);
		tok_run(1);
		tok_run(8);
		tok_space(SPACE_BASE);
		tok_space(8'hFF);
		tok_ref(1, 3);
		tok_ref(0, 3);
		tok_ref(MAX_DIST, 10);
		tok_ref(gen_count, 4);
		tok_ref(gen_count + 1, 3);
		add_code(8'h03);
		add_code(8'h41);
		start_record();
		add_code(8'hBF);
		start_record();
		tok_plain(8'h55);

		// Random records, some cut short or followed by stray bytes.
		while (pending_codes.size() < 60) begin
			start_record();
			repeat ($urandom_range(4, 30)) tok_random();
			case ($urandom_range(0, 5))
				0: begin
					add_code(8'($urandom_range(1, 8)));
					if ($urandom_range(0, 1) == 1)
						add_code(8'($urandom_range(0, 255)));
				end
				1: add_code(8'($urandom_range(128, 191)));
				2: repeat ($urandom_range(1, 4)) add_code(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end

		// One long record that fills and wraps the history window.
		start_record();
		repeat (6) tok_plain(8'($urandom_range(9, 127)));
		while (gen_count < HIST_DEPTH) begin
			if ($urandom_range(0, 7) != 0)
				tok_ref($urandom_range(1, min_of(gen_count, MAX_DIST)), 10);
			else
				tok_random();
		end
		repeat (15) tok_ref($urandom_range(1900, MAX_DIST), $urandom_range(3, 10));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_codes.size() != 0 || code_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatches == 0)
			$display("palmdoc_lz77_decompressor_tb: clean");
		else
			$display("palmdoc_lz77_decompressor_tb: errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("palmdoc_lz77_decompressor_tb: errors");
		$finish;
	end

endmodule
